// ===== hdl/pfde_pkg.sv =====
package pfde_pkg;

    localparam int DefWidth  = 128;
    localparam int DefHeight = 64;
    localparam int GlyphFirst = 32;
    localparam int GlyphLast  = 127;
    localparam int GlyphCols  = 6;
    localparam int QueueDepth = 2;

    localparam logic [3:0] OP_CLEAR   = 4'd0;
    localparam logic [3:0] OP_SET     = 4'd1;
    localparam logic [3:0] OP_RESET   = 4'd2;
    localparam logic [3:0] OP_INV     = 4'd3;
    localparam logic [3:0] OP_HSET    = 4'd4;
    localparam logic [3:0] OP_HINV    = 4'd5;
    localparam logic [3:0] OP_VSET    = 4'd6;
    localparam logic [3:0] OP_VINV    = 4'd7;
    localparam logic [3:0] OP_RECT    = 4'd8;
    localparam logic [3:0] OP_FILL    = 4'd9;
    localparam logic [3:0] OP_CHAR    = 4'd10;
    localparam logic [3:0] OP_READ    = 4'd11;

    localparam logic [1:0] MODE_CLR = 2'd0;
    localparam logic [1:0] MODE_SET = 2'd1;
    localparam logic [1:0] MODE_INV = 2'd2;
    localparam logic [1:0] MODE_GLY = 2'd3;

    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] end_x;
        logic [7:0] end_y;
        logic [7:0] run_length;
        logic [7:0] char_code;
        logic [9:0] byte_index;
    } req_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       rejected;
    } rsp_t;

    // classified job: a sweep over a box of columns x rows (counts minus one)
    typedef struct packed {
        logic       is_clear;
        logic       is_read;
        logic       is_rect;
        logic       noop;
        logic       rejected;
        logic [1:0] mode;
        logic [7:0] x0;
        logic [7:0] y0;
        logic [7:0] x1;
        logic [7:0] y1;
        logic [7:0] cols;
        logic [7:0] rows;
        logic [6:0] glyph;
        logic [9:0] byte_index;
    } job_t;

    function automatic logic [7:0] glyph_col(input logic [6:0] g, input logic [2:0] c);
        logic [7:0] r [0:95][0:5];
        r = '{
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h00,8'h2F,8'h00,8'h00},
        '{8'h00,8'h00,8'h07,8'h00,8'h07,8'h00},'{8'h00,8'h14,8'h7F,8'h14,8'h7F,8'h14},
        '{8'h00,8'h24,8'h2A,8'h7F,8'h2A,8'h12},'{8'h00,8'h62,8'h64,8'h08,8'h13,8'h23},
        '{8'h00,8'h36,8'h49,8'h55,8'h22,8'h50},'{8'h00,8'h00,8'h05,8'h03,8'h00,8'h00},
        '{8'h00,8'h00,8'h1C,8'h22,8'h41,8'h00},'{8'h00,8'h00,8'h41,8'h22,8'h1C,8'h00},
        '{8'h00,8'h14,8'h08,8'h3E,8'h08,8'h14},'{8'h00,8'h08,8'h08,8'h3E,8'h08,8'h08},
        '{8'h00,8'h00,8'h00,8'hA0,8'h60,8'h00},'{8'h00,8'h08,8'h08,8'h08,8'h08,8'h08},
        '{8'h00,8'h00,8'h60,8'h60,8'h00,8'h00},'{8'h00,8'h20,8'h10,8'h08,8'h04,8'h02},
        '{8'h00,8'h3E,8'h51,8'h49,8'h45,8'h3E},'{8'h00,8'h00,8'h42,8'h7F,8'h40,8'h00},
        '{8'h00,8'h42,8'h61,8'h51,8'h49,8'h46},'{8'h00,8'h21,8'h41,8'h45,8'h4B,8'h31},
        '{8'h00,8'h18,8'h14,8'h12,8'h7F,8'h10},'{8'h00,8'h27,8'h45,8'h45,8'h45,8'h39},
        '{8'h00,8'h3C,8'h4A,8'h49,8'h49,8'h30},'{8'h00,8'h01,8'h71,8'h09,8'h05,8'h03},
        '{8'h00,8'h36,8'h49,8'h49,8'h49,8'h36},'{8'h00,8'h06,8'h49,8'h49,8'h29,8'h1E},
        '{8'h00,8'h00,8'h36,8'h36,8'h00,8'h00},'{8'h00,8'h00,8'h56,8'h36,8'h00,8'h00},
        '{8'h00,8'h08,8'h14,8'h22,8'h41,8'h00},'{8'h00,8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h00,8'h41,8'h22,8'h14,8'h08},'{8'h00,8'h02,8'h01,8'h51,8'h09,8'h06},
        '{8'h00,8'h32,8'h49,8'h59,8'h51,8'h3E},'{8'h00,8'h7C,8'h12,8'h11,8'h12,8'h7C},
        '{8'h00,8'h7F,8'h49,8'h49,8'h49,8'h36},'{8'h00,8'h3E,8'h41,8'h41,8'h41,8'h22},
        '{8'h00,8'h7F,8'h41,8'h41,8'h22,8'h1C},'{8'h00,8'h7F,8'h49,8'h49,8'h49,8'h41},
        '{8'h00,8'h7F,8'h09,8'h09,8'h09,8'h01},'{8'h00,8'h3E,8'h41,8'h49,8'h49,8'h7A},
        '{8'h00,8'h7F,8'h08,8'h08,8'h08,8'h7F},'{8'h00,8'h00,8'h41,8'h7F,8'h41,8'h00},
        '{8'h00,8'h20,8'h40,8'h41,8'h3F,8'h01},'{8'h00,8'h7F,8'h08,8'h14,8'h22,8'h41},
        '{8'h00,8'h7F,8'h40,8'h40,8'h40,8'h40},'{8'h00,8'h7F,8'h02,8'h0C,8'h02,8'h7F},
        '{8'h00,8'h7F,8'h04,8'h08,8'h10,8'h7F},'{8'h00,8'h3E,8'h41,8'h41,8'h41,8'h3E},
        '{8'h00,8'h7F,8'h09,8'h09,8'h09,8'h06},'{8'h00,8'h3E,8'h41,8'h51,8'h21,8'h5E},
        '{8'h00,8'h7F,8'h09,8'h19,8'h29,8'h46},'{8'h00,8'h46,8'h49,8'h49,8'h49,8'h31},
        '{8'h00,8'h01,8'h01,8'h7F,8'h01,8'h01},'{8'h00,8'h3F,8'h40,8'h40,8'h40,8'h3F},
        '{8'h00,8'h1F,8'h20,8'h40,8'h20,8'h1F},'{8'h00,8'h3F,8'h40,8'h38,8'h40,8'h3F},
        '{8'h00,8'h63,8'h14,8'h08,8'h14,8'h63},'{8'h00,8'h07,8'h08,8'h70,8'h08,8'h07},
        '{8'h00,8'h61,8'h51,8'h49,8'h45,8'h43},'{8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00},
        '{8'h00,8'h55,8'h2A,8'h55,8'h2A,8'h55},'{8'h00,8'h00,8'h41,8'h41,8'h7F,8'h00},
        '{8'h00,8'h04,8'h02,8'h01,8'h02,8'h04},'{8'h00,8'h40,8'h40,8'h40,8'h40,8'h40},
        '{8'h00,8'h00,8'h01,8'h02,8'h04,8'h00},'{8'h00,8'h20,8'h54,8'h54,8'h54,8'h78},
        '{8'h00,8'h7F,8'h48,8'h44,8'h44,8'h38},'{8'h00,8'h38,8'h44,8'h44,8'h44,8'h20},
        '{8'h00,8'h38,8'h44,8'h44,8'h48,8'h7F},'{8'h00,8'h38,8'h54,8'h54,8'h54,8'h18},
        '{8'h00,8'h08,8'h7E,8'h09,8'h01,8'h02},'{8'h00,8'h18,8'hA4,8'hA4,8'hA4,8'h7C},
        '{8'h00,8'h7F,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h00,8'h44,8'h7D,8'h40,8'h00},
        '{8'h00,8'h40,8'h80,8'h84,8'h7D,8'h00},'{8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00},
        '{8'h00,8'h00,8'h41,8'h7F,8'h40,8'h00},'{8'h00,8'h7C,8'h04,8'h18,8'h04,8'h78},
        '{8'h00,8'h7C,8'h08,8'h04,8'h04,8'h78},'{8'h00,8'h38,8'h44,8'h44,8'h44,8'h38},
        '{8'h00,8'hFC,8'h24,8'h24,8'h24,8'h18},'{8'h00,8'h18,8'h24,8'h24,8'h18,8'hFC},
        '{8'h00,8'h7C,8'h08,8'h04,8'h04,8'h08},'{8'h00,8'h48,8'h54,8'h54,8'h54,8'h20},
        '{8'h00,8'h04,8'h3F,8'h44,8'h40,8'h20},'{8'h00,8'h3C,8'h40,8'h40,8'h20,8'h7C},
        '{8'h00,8'h1C,8'h20,8'h40,8'h20,8'h1C},'{8'h00,8'h3C,8'h40,8'h30,8'h40,8'h3C},
        '{8'h00,8'h44,8'h28,8'h10,8'h28,8'h44},'{8'h00,8'h1C,8'hA0,8'hA0,8'hA0,8'h7C},
        '{8'h00,8'h44,8'h64,8'h54,8'h4C,8'h44},'{8'h14,8'h14,8'h14,8'h14,8'h14,8'h14},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},'{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}};
        if (g > 7'd95 || c > 3'd5)
        begin
            return 8'h00;
        end
        return r[g][c];
    endfunction

endpackage

// ===== hdl/pfde_ram.sv =====
module pfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/pfde_front.sv =====
module pfde_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pfde_pkg::req_t request,
    output logic           busy,
    output logic           push,
    output pfde_pkg::job_t job,
    input  logic           q_full,
    input  logic           back_idle,
    input  logic           q_empty
);
    import pfde_pkg::*;

    logic   pend_reg;
    logic   pend_next;
    logic   acc;
    logic   ok;
    job_t   j;
    logic [7:0] wl;
    logic [7:0] hl;

    // one request in flight: result of a read must see all earlier writes
    assign busy = pend_reg || !back_idle;
    assign acc  = start && !busy;
    assign ok   = 1'b1;

    always_comb
    begin
        wl = request.end_x - request.pos_x + 8'd1;
        hl = request.end_y - request.pos_y;
        j = '0;
        j.x0 = request.pos_x;
        j.y0 = request.pos_y;
        j.x1 = request.end_x;
        j.y1 = request.end_y;
        j.byte_index = request.byte_index;
        j.glyph = 7'(request.char_code - 8'd32);
        j.mode = MODE_SET;
        case (request.req_type)
            OP_CLEAR: j.is_clear = 1'b1;
            OP_SET, OP_RESET, OP_INV:
            begin
                j.mode = (request.req_type == OP_SET) ? MODE_SET :
                         (request.req_type == OP_RESET) ? MODE_CLR : MODE_INV;
            end
            OP_HSET, OP_HINV, OP_VSET, OP_VINV:
            begin
                j.mode = request.req_type[0] ? MODE_INV : MODE_SET;
                j.noop = (request.run_length == 8'd0);
                if (request.req_type[1])
                begin
                    j.rows = request.run_length - 8'd1;
                end
                else
                begin
                    j.cols = request.run_length - 8'd1;
                end
            end
            OP_RECT:
            begin
                j.is_rect = 1'b1;
                j.noop = (wl == 8'd0) && (hl == 8'd0);
                j.cols = wl - 8'd1;
                j.rows = hl;
            end
            OP_FILL:
            begin
                j.noop = (wl == 8'd0);
                j.cols = wl - 8'd1;
                j.rows = hl;
            end
            OP_CHAR:
            begin
                j.mode = MODE_GLY;
                j.rejected = (request.char_code < 8'd32) || (request.char_code > 8'd127);
                j.noop = j.rejected;
                j.cols = 8'd5;
                j.rows = 8'd7;
            end
            OP_READ: j.is_read = 1'b1;
            default:
            begin
                j.rejected = 1'b1;
                j.noop = 1'b1;
            end
        endcase
    end

    assign push = acc && ok && !q_full;
    assign job  = j;

    always_comb
    begin
        pend_next = pend_reg;
        if (acc)
        begin
            pend_next = 1'b1;
        end
        else if (pend_reg && back_idle && q_empty)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end
endmodule

// ===== hdl/pfde_queue.sv =====
module pfde_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pfde_pkg::job_t din,
    input  logic           pop,
    output pfde_pkg::job_t dout,
    output logic           empty,
    output logic           full
);
    import pfde_pkg::*;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t          slot_reg [0:DEPTH-1];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [AW:0]   cnt_reg;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign dout  = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end
endmodule

// ===== hdl/pfde_back.sv =====
module pfde_back #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  pfde_pkg::job_t job,
    output logic           pop,
    output logic           idle,
    output logic           done,
    output pfde_pkg::rsp_t result
);
    import pfde_pkg::*;

    localparam int Pages = (DISPLAY_HEIGHT + 7) / 8;
    localparam int Bytes = DISPLAY_WIDTH * Pages;
    localparam int AW    = $clog2(Bytes);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WIPE = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_WRIT = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_RDB  = 3'd6;

    logic [2:0]    st_reg, st_next;
    job_t          jb_reg, jb_next;
    logic [7:0]    i_reg, i_next;
    logic [7:0]    j_reg, j_next;
    logic [AW-1:0] wc_reg, wc_next;
    logic          rej_reg, rej_next;
    logic          ovr_reg, ovr_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    logic [7:0]    px, py;
    logic          inside_px, pix_on;
    logic [15:0]   lin;
    logic [7:0]    col;

    pfde_ram #(.WIDTH(8), .DEPTH(Bytes)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // rectangles sweep their whole box but write only its border pixels
    always_comb
    begin
        px = jb_reg.x0 + i_reg;
        py = jb_reg.y0 + j_reg;
        inside_px = (32'(px) < DISPLAY_WIDTH) && (32'(py) < DISPLAY_HEIGHT);
        if (jb_reg.is_rect)
        begin
            inside_px = inside_px && (((i_reg == 8'd0 || i_reg == jb_reg.cols)
                        && j_reg != jb_reg.rows) || (j_reg == 8'd0 && jb_reg.cols != 8'hFF
                        && (jb_reg.x1 - jb_reg.x0 + 8'd1) != 8'd0)
                        || (py == jb_reg.y1 && (jb_reg.x1 - jb_reg.x0 + 8'd1) != 8'd0));
            // vertical edges at pos_x and end_x (may coincide)
            if (px != jb_reg.x0 && px != jb_reg.x1 && j_reg != 8'd0 && py != jb_reg.y1)
            begin
                inside_px = 1'b0;
            end
        end
        lin = 16'(py >> 3) * 16'(DISPLAY_WIDTH) + 16'(px);
        col = glyph_col(jb_reg.glyph, i_reg[2:0]);
        pix_on = col[j_reg[2:0]];
    end

    always_comb
    begin
        st_next = st_reg;
        jb_next = jb_reg;
        i_next  = i_reg;
        j_next  = j_reg;
        wc_next = wc_reg;
        rej_next = rej_reg;
        ovr_next = ovr_reg;
        pop = 1'b0;
        done = 1'b0;
        result = '0;
        we = 1'b0;
        waddr = lin[AW-1:0];
        wdata = rdata;
        raddr = lin[AW-1:0];
        case (st_reg)
            S_WIPE:
            begin
                we = 1'b1;
                waddr = wc_reg;
                wdata = 8'h00;
                wc_next = wc_reg + 1'b1;
                if (32'(wc_reg) == Bytes - 1)
                begin
                    st_next = ovr_reg ? S_FIN : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    jb_next = job;
                    i_next = 8'd0;
                    j_next = 8'd0;
                    rej_next = job.rejected;
                    ovr_next = 1'b1;
                    wc_next = '0;
                    if (job.is_clear)
                    begin
                        st_next = S_WIPE;
                    end
                    else if (job.is_read)
                    begin
                        st_next = S_RDB;
                    end
                    else if (job.noop)
                    begin
                        st_next = S_FIN;
                    end
                    else
                    begin
                        st_next = S_ADDR;
                    end
                end
            end
            S_RDB:
            begin
                raddr = jb_reg.byte_index[AW-1:0];
                st_next = S_READ;
            end
            S_ADDR:
            begin
                st_next = S_READ;
            end
            S_READ:
            begin
                if (jb_reg.is_read)
                begin
                    done = 1'b1;
                    result.read_byte = (32'(jb_reg.byte_index) < Bytes) ? rdata : 8'h00;
                    st_next = S_IDLE;
                end
                else
                begin
                    st_next = S_WRIT;
                end
            end
            S_WRIT:
            begin
                we = inside_px;
                case (jb_reg.mode)
                    MODE_CLR: wdata = rdata & ~(8'd1 << py[2:0]);
                    MODE_SET: wdata = rdata | (8'd1 << py[2:0]);
                    MODE_INV: wdata = rdata ^ (8'd1 << py[2:0]);
                    default:  wdata = pix_on ? (rdata | (8'd1 << py[2:0]))
                                             : (rdata & ~(8'd1 << py[2:0]));
                endcase
                if (j_reg == jb_reg.rows)
                begin
                    j_next = 8'd0;
                    if (i_reg == jb_reg.cols)
                    begin
                        st_next = S_FIN;
                    end
                    else
                    begin
                        i_next = i_reg + 8'd1;
                        st_next = S_ADDR;
                    end
                end
                else
                begin
                    j_next = j_reg + 8'd1;
                    st_next = S_ADDR;
                end
            end
            S_FIN:
            begin
                done = 1'b1;
                result.rejected = rej_reg;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    assign idle = (st_reg == S_IDLE) && !done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_WIPE;
            wc_reg  <= '0;
            ovr_reg <= 1'b0;
            rej_reg <= 1'b0;
            i_reg   <= '0;
            j_reg   <= '0;
        end
        else
        begin
            st_reg  <= st_next;
            wc_reg  <= wc_next;
            ovr_reg <= ovr_next;
            rej_reg <= rej_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jb_reg <= jb_next;
    end
endmodule

// ===== hdl/page_framebuffer_draw_engine.sv =====
// result strobe: a read returns the addressed byte; a rejected or empty request gives its strobe
// without touching the store; a draw sweeps a box of pixels (one read-modify-write of a store byte
// per pixel; rectangles sweep their whole box); clear all wipes the whole store before its strobe
// throughput: one request at a time; busy stays high past its result strobe until pend_reg clears
// reset: async active low; after reset busy stays high while the store is wiped,
// one byte a cycle; the receiver cannot stall
module page_framebuffer_draw_engine #(
    parameter int DISPLAY_WIDTH  = pfde_pkg::DefWidth,
    parameter int DISPLAY_HEIGHT = pfde_pkg::DefHeight
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pfde_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output pfde_pkg::rsp_t result
);
    import pfde_pkg::*;

    logic push, pop, q_empty, q_full, back_idle, fbusy;
    job_t jin, jout;

    pfde_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .request(request), .busy(fbusy),
        .push(push), .job(jin), .q_full(q_full), .back_idle(back_idle), .q_empty(q_empty)
    );

    pfde_queue #(.DEPTH(QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .din(jin), .pop(pop),
        .dout(jout), .empty(q_empty), .full(q_full)
    );

    pfde_back #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT)) u_back (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .job(jout), .pop(pop),
        .idle(back_idle), .done(done), .result(result)
    );

    assign busy = fbusy || !back_idle;
endmodule

// ===== hdl/pfde_checker.sv =====
module pfde_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input pfde_pkg::rsp_t result
);
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result without request in flight");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("back to back strobes");
    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accept did not raise busy");
    a_read_rej: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.rejected) |-> (result.read_byte == 8'h00))
        else $error("rejected result carries data");
endmodule

bind page_framebuffer_draw_engine pfde_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .result(result)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pfde_pkg::*;

    localparam int ScrW      = 128;
    localparam int ScrH      = 64;
    localparam int StoreSize = ScrW * ((ScrH + 7) / 8);
    localparam int RandCount = 1000;
    localparam int TailItems = 150;

    logic clk;
    logic rst_n;
    logic start;
    req_t request;
    logic busy;
    logic done;
    rsp_t result;

    page_framebuffer_draw_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .request(request),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // 6x8 font, codes 32..127, six column bytes each
    logic [7:0] font_rom [0:575] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h2F,8'h00,8'h00,
        8'h00,8'h00,8'h07,8'h00,8'h07,8'h00, 8'h00,8'h14,8'h7F,8'h14,8'h7F,8'h14,
        8'h00,8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h00,8'h62,8'h64,8'h08,8'h13,8'h23,
        8'h00,8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h00,8'h05,8'h03,8'h00,8'h00,
        8'h00,8'h00,8'h1C,8'h22,8'h41,8'h00, 8'h00,8'h00,8'h41,8'h22,8'h1C,8'h00,
        8'h00,8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h00,8'h08,8'h08,8'h3E,8'h08,8'h08,
        8'h00,8'h00,8'h00,8'hA0,8'h60,8'h00, 8'h00,8'h08,8'h08,8'h08,8'h08,8'h08,
        8'h00,8'h00,8'h60,8'h60,8'h00,8'h00, 8'h00,8'h20,8'h10,8'h08,8'h04,8'h02,
        8'h00,8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h00,8'h42,8'h7F,8'h40,8'h00,
        8'h00,8'h42,8'h61,8'h51,8'h49,8'h46, 8'h00,8'h21,8'h41,8'h45,8'h4B,8'h31,
        8'h00,8'h18,8'h14,8'h12,8'h7F,8'h10, 8'h00,8'h27,8'h45,8'h45,8'h45,8'h39,
        8'h00,8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h00,8'h01,8'h71,8'h09,8'h05,8'h03,
        8'h00,8'h36,8'h49,8'h49,8'h49,8'h36, 8'h00,8'h06,8'h49,8'h49,8'h29,8'h1E,
        8'h00,8'h00,8'h36,8'h36,8'h00,8'h00, 8'h00,8'h00,8'h56,8'h36,8'h00,8'h00,
        8'h00,8'h08,8'h14,8'h22,8'h41,8'h00, 8'h00,8'h14,8'h14,8'h14,8'h14,8'h14,
        8'h00,8'h00,8'h41,8'h22,8'h14,8'h08, 8'h00,8'h02,8'h01,8'h51,8'h09,8'h06,
        8'h00,8'h32,8'h49,8'h59,8'h51,8'h3E, 8'h00,8'h7C,8'h12,8'h11,8'h12,8'h7C,
        8'h00,8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h00,8'h3E,8'h41,8'h41,8'h41,8'h22,
        8'h00,8'h7F,8'h41,8'h41,8'h22,8'h1C, 8'h00,8'h7F,8'h49,8'h49,8'h49,8'h41,
        8'h00,8'h7F,8'h09,8'h09,8'h09,8'h01, 8'h00,8'h3E,8'h41,8'h49,8'h49,8'h7A,
        8'h00,8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h00,8'h41,8'h7F,8'h41,8'h00,
        8'h00,8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h00,8'h7F,8'h08,8'h14,8'h22,8'h41,
        8'h00,8'h7F,8'h40,8'h40,8'h40,8'h40, 8'h00,8'h7F,8'h02,8'h0C,8'h02,8'h7F,
        8'h00,8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h00,8'h3E,8'h41,8'h41,8'h41,8'h3E,
        8'h00,8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h00,8'h3E,8'h41,8'h51,8'h21,8'h5E,
        8'h00,8'h7F,8'h09,8'h19,8'h29,8'h46, 8'h00,8'h46,8'h49,8'h49,8'h49,8'h31,
        8'h00,8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h00,8'h3F,8'h40,8'h40,8'h40,8'h3F,
        8'h00,8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h00,8'h3F,8'h40,8'h38,8'h40,8'h3F,
        8'h00,8'h63,8'h14,8'h08,8'h14,8'h63, 8'h00,8'h07,8'h08,8'h70,8'h08,8'h07,
        8'h00,8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00,
        8'h00,8'h55,8'h2A,8'h55,8'h2A,8'h55, 8'h00,8'h00,8'h41,8'h41,8'h7F,8'h00,
        8'h00,8'h04,8'h02,8'h01,8'h02,8'h04, 8'h00,8'h40,8'h40,8'h40,8'h40,8'h40,
        8'h00,8'h00,8'h01,8'h02,8'h04,8'h00, 8'h00,8'h20,8'h54,8'h54,8'h54,8'h78,
        8'h00,8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h00,8'h38,8'h44,8'h44,8'h44,8'h20,
        8'h00,8'h38,8'h44,8'h44,8'h48,8'h7F, 8'h00,8'h38,8'h54,8'h54,8'h54,8'h18,
        8'h00,8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h00,8'h18,8'hA4,8'hA4,8'hA4,8'h7C,
        8'h00,8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h00,8'h44,8'h7D,8'h40,8'h00,
        8'h00,8'h40,8'h80,8'h84,8'h7D,8'h00, 8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00,
        8'h00,8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h00,8'h7C,8'h04,8'h18,8'h04,8'h78,
        8'h00,8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h38,8'h44,8'h44,8'h44,8'h38,
        8'h00,8'hFC,8'h24,8'h24,8'h24,8'h18, 8'h00,8'h18,8'h24,8'h24,8'h18,8'hFC,
        8'h00,8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h00,8'h48,8'h54,8'h54,8'h54,8'h20,
        8'h00,8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h00,8'h3C,8'h40,8'h40,8'h20,8'h7C,
        8'h00,8'h1C,8'h20,8'h40,8'h20,8'h1C, 8'h00,8'h3C,8'h40,8'h30,8'h40,8'h3C,
        8'h00,8'h44,8'h28,8'h10,8'h28,8'h44, 8'h00,8'h1C,8'hA0,8'hA0,8'hA0,8'h7C,
        8'h00,8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h14,8'h14,8'h14,8'h14,8'h14,8'h14,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
    };

    logic [7:0] shadow_fb [0:StoreSize-1];
    req_t       pending_reqs [$];
    rsp_t       expected_rsps [$];
    int         gap_left;
    int         accepted_cnt;
    int         checked_cnt;
    int         reads_nonzero;
    int         reject_cnt;
    int         error_cnt;
    bit         tail_phase;

    function automatic void plot(input logic [7:0] x, input logic [7:0] y,
                                 input logic [1:0] mode);
        int addr;
        if (x >= ScrW || y >= ScrH)
        begin
            return;
        end
        addr = int'(x) + int'(y >> 3) * ScrW;
        case (mode)
            MODE_SET: shadow_fb[addr][y[2:0]] = 1'b1;
            MODE_INV: shadow_fb[addr][y[2:0]] = ~shadow_fb[addr][y[2:0]];
            default:  shadow_fb[addr][y[2:0]] = 1'b0;
        endcase
    endfunction

    function automatic void draw_run(input logic [7:0] x, input logic [7:0] y,
                                     input logic [7:0] len, input bit vert,
                                     input logic [1:0] mode);
        logic [7:0] k;
        for (int i = 0; i < len; i++)
        begin
            k = i[7:0];
            if (vert)
            begin
                plot(x, y + k, mode);
            end
            else
            begin
                plot(x + k, y, mode);
            end
        end
    endfunction

    // applies one request to the shadow buffer and returns what the block should answer
    function automatic rsp_t apply_draw(input req_t r);
        rsp_t       rsp;
        logic [7:0] w;
        logic [7:0] h;
        logic [7:0] col;
        rsp = '0;
        w   = r.end_x - r.pos_x + 8'd1;
        h   = r.end_y - r.pos_y;
        case (r.req_type)
            OP_CLEAR:
            begin
                for (int a = 0; a < StoreSize; a++)
                begin
                    shadow_fb[a] = 8'h00;
                end
            end
            OP_SET:   plot(r.pos_x, r.pos_y, MODE_SET);
            OP_RESET: plot(r.pos_x, r.pos_y, MODE_CLR);
            OP_INV:   plot(r.pos_x, r.pos_y, MODE_INV);
            OP_HSET:  draw_run(r.pos_x, r.pos_y, r.run_length, 1'b0, MODE_SET);
            OP_HINV:  draw_run(r.pos_x, r.pos_y, r.run_length, 1'b0, MODE_INV);
            OP_VSET:  draw_run(r.pos_x, r.pos_y, r.run_length, 1'b1, MODE_SET);
            OP_VINV:  draw_run(r.pos_x, r.pos_y, r.run_length, 1'b1, MODE_INV);
            OP_RECT:
            begin
                draw_run(r.pos_x, r.pos_y, w, 1'b0, MODE_SET);
                draw_run(r.pos_x, r.end_y, w, 1'b0, MODE_SET);
                draw_run(r.pos_x, r.pos_y, h, 1'b1, MODE_SET);
                draw_run(r.end_x, r.pos_y, h, 1'b1, MODE_SET);
            end
            OP_FILL:
            begin
                for (int i = 0; i < w; i++)
                begin
                    for (int j = 0; j <= h; j++)
                    begin
                        plot(r.pos_x + i[7:0], r.pos_y + j[7:0], MODE_SET);
                    end
                end
            end
            OP_CHAR:
            begin
                if (r.char_code < GlyphFirst || r.char_code > GlyphLast)
                begin
                    rsp.rejected = 1'b1;
                end
                else
                begin
                    for (int i = 0; i < GlyphCols; i++)
                    begin
                        col = font_rom[(int'(r.char_code) - GlyphFirst) * GlyphCols + i];
                        for (int j = 0; j < 8; j++)
                        begin
                            plot(r.pos_x + i[7:0], r.pos_y + j[7:0],
                                 col[j] ? MODE_SET : MODE_CLR);
                        end
                    end
                end
            end
            OP_READ:
            begin
                if (r.byte_index < StoreSize)
                begin
                    rsp.read_byte = shadow_fb[r.byte_index];
                end
            end
            default: rsp.rejected = 1'b1;
        endcase
        return rsp;
    endfunction

    function automatic req_t mk_req(input logic [3:0] op, input logic [7:0] x,
                                    input logic [7:0] y, input logic [7:0] ex,
                                    input logic [7:0] ey, input logic [7:0] len,
                                    input logic [7:0] code, input logic [9:0] idx);
        req_t r;
        r.req_type   = op;
        r.pos_x      = x;
        r.pos_y      = y;
        r.end_x      = ex;
        r.end_y      = ey;
        r.run_length = len;
        r.char_code  = code;
        r.byte_index = idx;
        return r;
    endfunction

    // random request; unused fields carry random noise
    function automatic req_t rand_req(input int last_x, input int last_y);
        req_t r;
        int   sel;
        r   = req_t'({$urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            r.req_type = OP_READ;
            if ($urandom_range(0, 3) != 0)
            begin
                // look near the last drawing
                r.byte_index = 10'((last_x + $urandom_range(0, 8)) % ScrW
                                   + (((last_y + $urandom_range(0, 15)) % ScrH) / 8) * ScrW);
            end
        end
        else if (sel < 40)
        begin
            r.req_type = 4'($urandom_range(12, 15));
        end
        else if (sel < 41)
        begin
            r.req_type = OP_CLEAR;
        end
        else
        begin
            r.req_type = 4'($urandom_range(1, 10));
            if ($urandom_range(0, 3) != 0)
            begin
                r.pos_x = 8'($urandom_range(0, ScrW + 8));
                r.pos_y = 8'($urandom_range(0, ScrH + 8));
            end
            if ($urandom_range(0, 3) != 0)
            begin
                r.run_length = 8'($urandom_range(0, 40));
            end
            if (r.req_type == OP_FILL || r.req_type == OP_RECT)
            begin
                if (r.req_type == OP_FILL || $urandom_range(0, 19) != 0)
                begin
                    r.end_x = r.pos_x + 8'($urandom_range(0, 12));
                    r.end_y = r.pos_y + 8'($urandom_range(0, 12));
                end
            end
            if (r.req_type == OP_CHAR && $urandom_range(0, 7) != 0)
            begin
                r.char_code = 8'($urandom_range(GlyphFirst, GlyphLast));
            end
        end
        return r;
    endfunction

    initial
    begin
        req_t r;
        int   lx;
        int   ly;
        start   = 1'b0;
        request = '0;
        rst_n   = 1'b0;
        gap_left      = 0;
        accepted_cnt  = 0;
        checked_cnt   = 0;
        reads_nonzero = 0;
        reject_cnt    = 0;
        error_cnt     = 0;
        tail_phase    = 1'b0;
        for (int a = 0; a < StoreSize; a++)
        begin
            shadow_fb[a] = 8'h00;
        end

        // directed: corners, clipping, wrap, every opcode and the odd characters
        pending_reqs.push_back(mk_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd0));
        pending_reqs.push_back(mk_req(OP_SET, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_SET, 127, 63, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_SET, 255, 255, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd1023));
        pending_reqs.push_back(mk_req(OP_INV, 0, 1, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_RESET, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd0));
        pending_reqs.push_back(mk_req(OP_HSET, 250, 8, 0, 0, 255, 0, 0));
        pending_reqs.push_back(mk_req(OP_HINV, 120, 9, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_VSET, 5, 250, 0, 0, 20, 0, 0));
        pending_reqs.push_back(mk_req(OP_VINV, 5, 0, 0, 0, 70, 0, 0));
        pending_reqs.push_back(mk_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd5));
        pending_reqs.push_back(mk_req(OP_RECT, 10, 10, 20, 30, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_RECT, 100, 50, 4, 4, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_FILL, 30, 20, 35, 27, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_CHAR, 60, 3, 0, 0, 0, 8'd65, 0));
        pending_reqs.push_back(mk_req(OP_CHAR, 124, 60, 0, 0, 0, 8'd126, 0));
        pending_reqs.push_back(mk_req(OP_CHAR, 40, 40, 0, 0, 0, 8'd31, 0));
        pending_reqs.push_back(mk_req(OP_CHAR, 40, 40, 0, 0, 0, 8'd128, 0));
        pending_reqs.push_back(mk_req(OP_CHAR, 70, 30, 0, 0, 0, 8'd127, 0));
        pending_reqs.push_back(mk_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd513));
        pending_reqs.push_back(mk_req(4'd12, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(4'd15, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                      10'h3FF));
        pending_reqs.push_back(mk_req(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk_req(OP_READ, 0, 0, 0, 0, 0, 0, 10'd0));

        lx = 0;
        ly = 0;
        for (int n = 0; n < RandCount; n++)
        begin
            r = rand_req(lx, ly);
            if (r.req_type != OP_READ)
            begin
                lx = r.pos_x;
                ly = r.pos_y;
            end
            // a couple of full-screen fills
            if (n == 300 || n == 700)
            begin
                r = mk_req(OP_FILL, 8'($urandom_range(0, 3)), 0, 255, 255, 0, 0, 0);
            end
            pending_reqs.push_back(r);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && start == 1'b0);
        wait (expected_rsps.size() == 0);
        repeat (50) @(posedge clk);
        if (expected_rsps.size() != 0)
        begin
            error_cnt++;
        end
        $display("covered %0d requests (%0d checked), %0d non-zero reads, %0d rejects",
                 accepted_cnt, checked_cnt, reads_nonzero, reject_cnt);
        $display("all opcodes incl. unknown ones, clipping, wrap and full-screen fills");
        if (error_cnt == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // request driver
    always @(posedge clk)
    begin
        bit   free;
        req_t nxt;
        free = 1'b1;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_rsps.push_back(apply_draw(request));
                accepted_cnt++;
                if (pending_reqs.size() <= TailItems)
                begin
                    tail_phase = 1'b1;
                end
                if (!tail_phase && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(1, 8);
                end
            end
            else if (start)
            begin
                free = 1'b0;
            end
            if (free)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    nxt = pending_reqs.pop_front();
                    request <= nxt;
                    start   <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: unexpected result read_byte=%h rejected=%b",
                         $time, result.read_byte, result.rejected);
                error_cnt++;
            end
            else
            begin
                exp_rsp = expected_rsps.pop_front();
                checked_cnt++;
                if (result.read_byte != 8'h00)
                begin
                    reads_nonzero++;
                end
                if (result.rejected)
                begin
                    reject_cnt++;
                end
                if (result.read_byte !== exp_rsp.read_byte)
                begin
                    $display("%0t: read_byte mismatch expected %h actual %h",
                             $time, exp_rsp.read_byte, result.read_byte);
                    error_cnt++;
                end
                if (result.rejected !== exp_rsp.rejected)
                begin
                    $display("%0t: rejected mismatch expected %b actual %b",
                             $time, exp_rsp.rejected, result.rejected);
                    error_cnt++;
                end
            end
        end
    end

    initial
    begin
        #200ms;
        $display("timeout with %0d results outstanding", expected_rsps.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pfde_pkg.sv
hdl/pfde_ram.sv
hdl/pfde_front.sv
hdl/pfde_queue.sv
hdl/pfde_back.sv
hdl/page_framebuffer_draw_engine.sv
hdl/pfde_checker.sv
tb/tb.sv
